// ===== hw/rtl/sce_pkg.sv =====
// sce_pkg: types, command codes and constants of the stack calculator engine.
// No dependencies.
package sce_pkg;

  localparam int DefStackDepth = 32;
  localparam int WordW = 32;
  localparam int DepthOutW = 6;

  typedef enum logic [3:0] {
    CMD_PUSH = 4'd0, CMD_POP = 4'd1, CMD_ADD = 4'd2, CMD_SUB = 4'd3,
    CMD_MUL = 4'd4, CMD_DIV = 4'd5, CMD_NEG = 4'd6, CMD_NE = 4'd7,
    CMD_EQ = 4'd8, CMD_LE = 4'd9, CMD_GE = 4'd10, CMD_LT = 4'd11,
    CMD_GT = 4'd12, CMD_GCD = 4'd13, CMD_FACT = 4'd14, CMD_LOG2 = 4'd15
  } cmd_t;

  typedef struct packed {
    logic [3:0]        cmd;
    logic signed [31:0] push_value;
  } sce_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               printed;
    logic               underflow;
    logic               overflow;
    logic               divide_by_zero;
    logic               bad_operand;
    logic [5:0]         depth;
  } sce_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_X, ST_WAIT_X, ST_RD_Y, ST_WAIT_Y, ST_EXEC, ST_MUL,
    ST_DIV, ST_GCD, ST_FACT, ST_LOG2, ST_PUT
  } state_t;

endpackage

// ===== hw/rtl/sce_ram.sv =====
// sce_ram: generic single-port RAM, registered read.
// No dependencies.
module sce_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hw/rtl/sce_div.sv =====
// sce_div: radix-2 restoring divider, 32 steps, one bit a cycle.
// Unsigned quotient and remainder of magnitudes; caller fixes signs.
// Uses sce_pkg.
module sce_div
  import sce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);
  logic [31:0] quo;
  logic [32:0] rem;
  logic [31:0] dsr;
  logic [5:0]  cnt;
  logic        run;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[31]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 6'd32;
        quo <= dividend;
        rem <= '0;
        dsr <= divisor;
      end else if (run) begin
        if (!trial[32]) begin
          rem <= trial;
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[31:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;
  assign remainder = rem[31:0];
endmodule

// ===== hw/rtl/stack_calculator_engine_unit.sv =====
// stack_calculator_engine_unit: stack calculator, top level.
// Uses sce_pkg, sce_ram, sce_div.
//
// channel  | ports                | handshake
// ---------+----------------------+-------------------------------------
// command  | start, busy, cmd_in  | taken at edge with start & !busy
// result   | res_valid, res_out   | one-cycle strobe, cannot be stalled
//
// Push goes straight to the put state; other commands read their operands first,
// and mul, div, gcd, fact and log2 may then run in their own states. Gcd steps
// by remainders on the serial divider. Reset clears the count; the RAM is not
// cleared since only entries below the count are read. The strobe lands in
// the first cycle with busy low, so the next command can be taken at its end.
module stack_calculator_engine_unit
  import sce_pkg::*;
#(
  parameter int STACK_DEPTH = DefStackDepth
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  sce_in_t  cmd_in,
  output logic     res_valid,
  output sce_out_t res_out
);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  state_t state, state_next;
  logic [CW-1:0] count;
  cmd_t  cmd;
  logic [31:0] x, y, r, acc;
  logic under, dz, bad;
  logic [5:0] iter;
  logic [31:0] prod;
  logic mul_hi;

  // RAM port
  logic          we;
  logic [AW-1:0] addr;
  logic [31:0]   wdata, rdata;

  sce_ram #(.Width(WordW), .Depth(STACK_DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // divider: shared by div and gcd
  logic div_start, div_done;
  logic [31:0] div_a, div_b, div_q, div_r;
  sce_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a),
    .divisor(div_b), .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  logic [31:0] mag_x, mag_y;
  assign mag_x = x[31] ? 32'(-x) : x;
  assign mag_y = y[31] ? 32'(-y) : y;

  logic signed [31:0] sx, sy;
  assign sx = x;
  assign sy = y;

  logic [CW-1:0] count_dec;
  assign count_dec = count - CW'(1);

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    we = 1'b0;
    addr = count_dec[AW-1:0];
    wdata = r;
    div_start = 1'b0;
    div_a = mag_y;
    div_b = mag_x;
    case (state)
      ST_IDLE: if (start) begin
        if (cmd_in.cmd == CMD_PUSH) state_next = ST_PUT;
        else state_next = ST_RD_X;
      end
      ST_RD_X: begin
        state_next = (count == '0) ? ST_EXEC : ST_WAIT_X;
        if (count == '0 && !(cmd == CMD_POP || cmd == CMD_NEG ||
                            cmd == CMD_FACT || cmd == CMD_LOG2))
          state_next = ST_RD_Y;
      end
      ST_WAIT_X: begin
        if (cmd == CMD_POP || cmd == CMD_NEG || cmd == CMD_FACT ||
            cmd == CMD_LOG2) state_next = ST_EXEC;
        else state_next = ST_RD_Y;
      end
      ST_RD_Y: state_next = (count == '0) ? ST_EXEC : ST_WAIT_Y;
      ST_WAIT_Y: state_next = ST_EXEC;
      ST_EXEC: begin
        case (cmd)
          CMD_MUL: state_next = ST_MUL;
          CMD_DIV: begin
            if (x == '0) state_next = ST_PUT;
            else begin
              div_start = 1'b1;
              state_next = ST_DIV;
            end
          end
          CMD_GCD: state_next = ST_GCD;
          CMD_FACT: state_next = ST_FACT;
          CMD_LOG2: state_next = ST_LOG2;
          default: state_next = ST_PUT;
        endcase
      end
      ST_MUL: state_next = mul_hi ? ST_PUT : ST_MUL;
      ST_DIV: if (div_done) state_next = ST_PUT;
      ST_GCD: begin
        // a in y, b in x; iterate until b is zero, or stop at once if a equals b or bad
        div_a = y;
        div_b = x;
        if (iter == 6'd0) begin
          if (x == y || bad) state_next = ST_PUT;
          else if (x == '0) state_next = ST_PUT;
          else div_start = 1'b1;
        end
      end
      ST_FACT: if (iter == 6'd0) state_next = ST_PUT;
      ST_LOG2: if (iter == 6'd0) state_next = ST_PUT;
      ST_PUT: begin
        addr = count[AW-1:0];
        we = (cmd != CMD_POP) && (count < CW'(STACK_DEPTH));
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      res_valid <= 1'b0;
      iter <= '0;
      mul_hi <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      case (state)
        ST_IDLE: if (start) begin
          cmd <= cmd_t'(cmd_in.cmd);
          r <= cmd_in.push_value;
          under <= 1'b0;
          dz <= 1'b0;
          bad <= 1'b0;
        end
        ST_RD_X: if (count == '0) begin
          x <= '1;
          under <= 1'b1;
        end else count <= count_dec;
        ST_WAIT_X: x <= rdata;
        ST_RD_Y: if (count == '0) begin
          y <= '1;
          under <= 1'b1;
        end else count <= count_dec;
        ST_WAIT_Y: y <= rdata;
        ST_EXEC: begin
          mul_hi <= 1'b0;
          iter <= '0;
          case (cmd)
            CMD_POP: r <= x;
            CMD_ADD: r <= y + x;
            CMD_SUB: r <= y - x;
            CMD_MUL: prod <= x * y;
            CMD_DIV: if (x == '0) begin
              dz <= 1'b1;
              r <= '0;
            end
            CMD_NEG: r <= 32'(-x);
            CMD_NE: r <= {31'd0, sx != sy};
            CMD_EQ: r <= {31'd0, sx == sy};
            CMD_LE: r <= {31'd0, sy <= sx};
            CMD_GE: r <= {31'd0, sy >= sx};
            CMD_LT: r <= {31'd0, sy < sx};
            CMD_GT: r <= {31'd0, sy > sx};
            CMD_GCD: begin
              if (x == y) r <= x;
              else if (sx <= 0 || sy <= 0) begin
                bad <= 1'b1;
                r <= '0;
              end
            end
            CMD_FACT: begin
              acc <= 32'd1;
              if (sx >= 34 || sx <= 0) iter <= '0;
              else iter <= x[5:0];
            end
            CMD_LOG2: begin
              acc <= 32'd1;
              iter <= (sx > 1) ? 6'd32 : 6'd0;
              r <= '0;
            end
            default: r <= r;
          endcase
        end
        ST_MUL: begin
          r <= prod;
          mul_hi <= 1'b1;
        end
        ST_DIV: if (div_done) begin
          r <= (x[31] ^ y[31]) ? 32'(-div_q) : div_q;
        end
        ST_GCD: begin
          if (iter == 6'd0) begin
            if (x == y || bad) begin
            end else if (x == '0) r <= y;
            else iter <= 6'd1;
          end else if (div_done) begin
            y <= x;
            x <= div_r;
            iter <= '0;
          end
        end
        ST_FACT: if (iter != '0) begin
          acc <= 32'(acc * {26'd0, iter});
          iter <= iter - 6'd1;
        end else r <= (acc == '0) ? 32'd1 : acc;
        ST_LOG2: if (iter != '0) begin
          if ({1'b0, acc} < {1'b0, x}) begin
            acc <= {acc[30:0], 1'b0};
            r <= r + 32'd1;
            iter <= iter - 6'd1;
          end else iter <= '0;
        end
        ST_PUT: begin
          res_valid <= 1'b1;
          res_out.result_value <= r;
          res_out.printed <= (cmd == CMD_POP);
          res_out.underflow <= under;
          res_out.divide_by_zero <= dz;
          res_out.bad_operand <= bad;
          if (cmd != CMD_POP && count < CW'(STACK_DEPTH)) begin
            count <= count + CW'(1);
            res_out.overflow <= 1'b0;
            res_out.depth <= 6'(count + CW'(1));
          end else begin
            res_out.overflow <= (cmd != CMD_POP);
            res_out.depth <= 6'(count);
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== hw/rtl/sce_checker.sv =====
// sce_checker: port-level checks for stack_calculator_engine_unit.
// Uses sce_pkg; bound to the top level below.
module sce_checker
  import sce_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     res_valid,
  input sce_out_t res_out
);
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !busy) else $error("result while still busy");
  a_one_strobe: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> !res_valid) else $error("double result");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accept did not raise busy");
  a_depth: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_out.depth <= 6'd32) else $error("depth too large");
endmodule

bind stack_calculator_engine_unit sce_checker u_sce_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .res_valid(res_valid), .res_out(res_out)
);
